FILE: rtl/cil_pkg.sv
// Shared constants, codes and controller/datapath interface types for the id list.
package cil_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int ID_W    = 16;
  localparam int DATA_W  = 32;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;
  localparam int CAP_W   = 5;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int IN_W    = 56;
  localparam int OUT_W   = 48;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISSING = 2'd3;

  // Register word index of the capacity register.
  localparam logic [PADDR_W-3:0] REG_CAPACITY = '0;
  localparam logic [CAP_W-1:0]   CAP_RESET    = CAP_W'(DEPTH);

  typedef struct packed {
    logic                load;       // latch the incoming command
    logic                add;        // insert at the front
    logic                scan_clear; // restart the search at entry zero
    logic                scan_step;  // advance the search index
    logic                remove;     // close the gap at the search index
    logic                res_set;    // capture a result
    logic [STAT_W-1:0]   res_status;
    logic                res_hit;    // result carries the search index
    logic                emit;       // move the result to the output register
  } cil_ctl_t;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             full;
    logic             empty;
    logic             hit;
    logic             last;
    logic             out_free;
  } cil_sts_t;

endpackage

FILE: rtl/contiguous_id_list.sv
// Add, empty and unknown commands give their result without a search; a remove or
// lookup walks the list from entry zero until it matches or passes the last entry.
// Commands are handled one at a time: a new one is accepted the cycle after the result
// is loaded into the free output register, and the search examines one entry per cycle.
// Reset (synchronous, active high) empties the list, clears the output valid flag and
// sets capacity to 16; entry contents are not cleared.
module contiguous_id_list (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // command [1:0], record_id [17:2], record_data [49:18], zero fill [55:50]
  input  logic [cil_pkg::IN_W-1:0]      s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // status [1:0], position [5:2], found_data [37:6], entry_count [42:38], zero [47:43]
  output logic [cil_pkg::OUT_W-1:0]     m_tdata,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cil_pkg::PADDR_W-1:0]   paddr,
  input  logic [cil_pkg::PDATA_W-1:0]   pwdata,
  output logic [cil_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  cil_pkg::cil_ctl_t             ctl;
  cil_pkg::cil_sts_t             sts;
  logic [cil_pkg::CAP_W-1:0]     capacity;
  logic [cil_pkg::STAT_W-1:0]    out_status;
  logic [cil_pkg::IDX_W-1:0]     out_position;
  logic [cil_pkg::DATA_W-1:0]    out_found;
  logic [cil_pkg::CNT_W-1:0]     out_count;
  logic                          cap_sel;

  assign pready  = 1'b1;
  assign cap_sel = (paddr[cil_pkg::PADDR_W-1:2] == cil_pkg::REG_CAPACITY);
  assign prdata  = cap_sel ? cil_pkg::PDATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= cil_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready && cap_sel) begin
      capacity <= pwdata[cil_pkg::CAP_W-1:0];
    end
  end

  cil_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  cil_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .capacity     (capacity),
    .in_command   (s_tdata[1:0]),
    .in_id        (s_tdata[17:2]),
    .in_data      (s_tdata[49:18]),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_status   (out_status),
    .out_position (out_position),
    .out_found    (out_found),
    .out_count    (out_count)
  );

  assign m_tdata = {5'b0, out_count, out_found, out_position, out_status};

  // The list never reports more entries than the store holds.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_count <= cil_pkg::CNT_W'(cil_pkg::DEPTH)))
    else $error("entry count exceeds store depth");

  // A full refusal can only happen with at least one entry held.
  a_full_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_status == cil_pkg::ST_FULL) |-> (out_count != '0))
    else $error("full status with an empty list");

  // A remove only happens on a matching, non-empty list.
  a_remove_hit: assert property (@(posedge clk) disable iff (rst)
    ctl.remove |-> (sts.hit && !sts.empty))
    else $error("remove without a match");

  // After a command is accepted the block is busy and cannot accept another back to back.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted back to back");

endmodule

FILE: rtl/cil_datapath.sv
// Entry store, search index, count, result and output registers of the id list.
module cil_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  cil_pkg::cil_ctl_t           ctl,
  output cil_pkg::cil_sts_t           sts,
  input  logic [cil_pkg::CAP_W-1:0]   capacity,
  input  logic [cil_pkg::CMD_W-1:0]   in_command,
  input  logic [cil_pkg::ID_W-1:0]    in_id,
  input  logic [cil_pkg::DATA_W-1:0]  in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cil_pkg::STAT_W-1:0]  out_status,
  output logic [cil_pkg::IDX_W-1:0]   out_position,
  output logic [cil_pkg::DATA_W-1:0]  out_found,
  output logic [cil_pkg::CNT_W-1:0]   out_count
);

  logic [cil_pkg::ID_W-1:0]   ids  [cil_pkg::DEPTH];
  logic [cil_pkg::DATA_W-1:0] pays [cil_pkg::DEPTH];
  logic [cil_pkg::CNT_W-1:0]  count;
  logic [cil_pkg::CMD_W-1:0]  op;
  logic [cil_pkg::ID_W-1:0]   key;
  logic [cil_pkg::DATA_W-1:0] wdata;
  logic [cil_pkg::IDX_W-1:0]  idx;
  logic [cil_pkg::STAT_W-1:0] res_status;
  logic [cil_pkg::IDX_W-1:0]  res_pos;
  logic [cil_pkg::DATA_W-1:0] res_found;
  logic [cil_pkg::CNT_W-1:0]  limit;
  logic [cil_pkg::ID_W-1:0]   cur_id;
  logic [cil_pkg::DATA_W-1:0] cur_pay;

  // A capacity of zero acts as one, anything above the store size as the size.
  always_comb begin
    if (capacity == '0) begin
      limit = cil_pkg::CNT_W'(1);
    end else if (cil_pkg::CNT_W'(capacity) > cil_pkg::CNT_W'(cil_pkg::DEPTH)) begin
      limit = cil_pkg::CNT_W'(cil_pkg::DEPTH);
    end else begin
      limit = cil_pkg::CNT_W'(capacity);
    end
  end

  assign cur_id  = ids[idx];
  assign cur_pay = pays[idx];

  assign sts.op       = op;
  assign sts.full     = (count >= limit);
  assign sts.empty    = (count == '0);
  assign sts.hit      = (cur_id == key);
  assign sts.last     = ((cil_pkg::CNT_W'(idx) + cil_pkg::CNT_W'(1)) == count);
  assign sts.out_free = !out_valid || out_ready;

  // Entry store: shift back on add, shift forward from the match on remove.
  always_ff @(posedge clk) begin
    if (ctl.add) begin
      ids[0]  <= key;
      pays[0] <= wdata;
      for (int i = 1; i < cil_pkg::DEPTH; i++) begin
        ids[i]  <= ids[i-1];
        pays[i] <= pays[i-1];
      end
    end else if (ctl.remove) begin
      for (int i = 0; i < cil_pkg::DEPTH - 1; i++) begin
        if (cil_pkg::IDX_W'(i) >= idx) begin
          ids[i]  <= ids[i+1];
          pays[i] <= pays[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op    <= in_command;
      key   <= in_id;
      wdata <= in_data;
    end
    if (ctl.scan_clear) begin
      idx <= '0;
    end else if (ctl.scan_step) begin
      idx <= idx + cil_pkg::IDX_W'(1);
    end
    if (ctl.res_set) begin
      res_status <= ctl.res_status;
      res_pos    <= ctl.res_hit ? idx : '0;
      res_found  <= (ctl.res_hit && op == cil_pkg::CMD_LOOKUP) ? cur_pay : '0;
    end
    if (ctl.emit) begin
      out_status   <= res_status;
      out_position <= res_pos;
      out_found    <= res_found;
      out_count    <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.add) begin
        count <= count + cil_pkg::CNT_W'(1);
      end else if (ctl.remove) begin
        count <= count - cil_pkg::CNT_W'(1);
      end
      if (ctl.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/cil_ctrl.sv
// Command sequencer of the id list: decode, linear search and result hand-off.
module cil_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  cil_pkg::cil_sts_t sts,
  output cil_pkg::cil_ctl_t ctl
);

  typedef enum logic [1:0] {IDLE, DECIDE, SCAN, REPLY} state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      IDLE: begin
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = DECIDE;
        end
      end
      DECIDE: begin
        state_next  = REPLY;
        ctl.res_set = 1'b1;
        if (sts.op == cil_pkg::CMD_ADD) begin
          if (sts.full) begin
            ctl.res_status = cil_pkg::ST_FULL;
          end else begin
            ctl.add        = 1'b1;
            ctl.res_status = cil_pkg::ST_OK;
          end
        end else if (sts.op == cil_pkg::CMD_REMOVE || sts.op == cil_pkg::CMD_LOOKUP) begin
          if (sts.empty) begin
            ctl.res_status = cil_pkg::ST_EMPTY;
          end else begin
            ctl.res_set    = 1'b0;
            ctl.scan_clear = 1'b1;
            state_next     = SCAN;
          end
        end else begin
          // An unknown command changes nothing and reports ok.
          ctl.res_status = cil_pkg::ST_OK;
        end
      end
      SCAN: begin
        if (sts.hit) begin
          ctl.res_set    = 1'b1;
          ctl.res_hit    = 1'b1;
          ctl.res_status = cil_pkg::ST_OK;
          ctl.remove     = (sts.op == cil_pkg::CMD_REMOVE);
          state_next     = REPLY;
        end else if (sts.last) begin
          ctl.res_set    = 1'b1;
          ctl.res_status = cil_pkg::ST_MISSING;
          state_next     = REPLY;
        end else begin
          ctl.scan_step = 1'b1;
        end
      end
      REPLY: begin
        if (sts.out_free) begin
          ctl.emit   = 1'b1;
          state_next = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
